// ----- hw/rtl/vhtc_pkg.sv -----
package vhtc_pkg;

    // section geometry
    localparam int WORLD_HEIGHT   = 256;
    localparam int SECTION_HEIGHT = 16;
    localparam int SECTION_WIDTH  = 16;
    localparam int PLANE_TILES    = SECTION_WIDTH * SECTION_WIDTH;

    // field widths
    localparam int TILE_W    = 8;
    localparam int POS_W     = 4;
    localparam int REG_W     = 8;
    localparam int CFG_IDX_W = 2;

    // derived widths
    localparam int X_W     = $clog2(SECTION_WIDTH);
    localparam int COL_W   = $clog2(PLANE_TILES);
    localparam int PLANE_W = $clog2(SECTION_HEIGHT + 3);
    localparam int HGT_W   = $clog2(WORLD_HEIGHT + (1 << REG_W) + SECTION_HEIGHT);

    // stencil window over the previous plane: col-width .. col+width
    localparam int WIN_LEN = 2 * SECTION_WIDTH + 1;

    // front to back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TILE_W-1:0] TILE_HIDDEN = 8'hff;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SECTION_BASE = 2'd0,
        REG_CULL_KIND_A  = 2'd1,
        REG_CULL_KIND_B  = 2'd2,
        REG_CULL_KIND_C  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [REG_W-1:0] section_base_height;
        logic [REG_W-1:0] cull_kind_a;
        logic [REG_W-1:0] cull_kind_b;
        logic [REG_W-1:0] cull_kind_c;
    } cfg_t;

    // one classified tile on its way from front to back
    typedef struct packed {
        logic [TILE_W-1:0] tile;
        logic [TILE_W-1:0] ahead_tile;
        logic [X_W-1:0]    x;
        logic [X_W-1:0]    z;
        logic [POS_W-1:0]  y_lo;
        logic [POS_W-1:0]  y_hi;
        logic              start;
        logic              below_plane;
        logic              emit0;
        logic              emit1;
        logic              top_height;
        logic              last0;
        logic              last1;
        logic              empty;
    } entry_t;

    typedef struct packed {
        logic [TILE_W-1:0] tile_out;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_z;
        logic [POS_W-1:0]  pos_y;
        logic              section_empty;
        logic              last;
    } result_t;

    function automatic logic cullable(input logic [TILE_W-1:0] id, input cfg_t cfg);
        return id == cfg.cull_kind_a || id == cfg.cull_kind_b ||
               id == cfg.cull_kind_c || id == TILE_HIDDEN;
    endfunction

endpackage

// ----- hw/rtl/vhtc_if.sv -----
interface vhtc_in_if;
    logic                        valid;
    logic                        ready;
    logic [vhtc_pkg::TILE_W-1:0] tile_in;
    logic                        section_start;

    modport source (output valid, tile_in, section_start, input ready);
    modport sink   (input valid, tile_in, section_start, output ready);
endinterface

interface vhtc_out_if;
    logic                        valid;
    logic                        ready;
    logic [vhtc_pkg::TILE_W-1:0] tile_out;
    logic [vhtc_pkg::POS_W-1:0]  pos_x;
    logic [vhtc_pkg::POS_W-1:0]  pos_z;
    logic [vhtc_pkg::POS_W-1:0]  pos_y;
    logic                        section_empty;
    logic                        last;

    modport source (output valid, tile_out, pos_x, pos_z, pos_y, section_empty, last,
                    input ready);
    modport sink   (input valid, tile_out, pos_x, pos_z, pos_y, section_empty, last,
                    output ready);
endinterface

// ----- hw/rtl/vhtc_ram.sv -----
module vhtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/vhtc_front.sv -----
module vhtc_front (
    input  logic              clk,
    input  logic              rst_n,
    vhtc_in_if.sink           tiles,
    input  vhtc_pkg::cfg_t    cfg,
    output vhtc_pkg::entry_t  ent,
    output logic              ent_valid,
    input  logic              ent_ready
);

    logic [vhtc_pkg::PLANE_W-1:0] plane_reg, plane_next;
    logic [vhtc_pkg::COL_W-1:0]   col_reg, col_next;
    logic [vhtc_pkg::X_W-1:0]     x_reg, x_next;
    logic [vhtc_pkg::X_W-1:0]     z_reg, z_next;
    logic                         any_reg, any_next;
    logic                         f1_v_reg, f1_v_next;
    vhtc_pkg::entry_t             f1_reg, f1_next;

    logic                         start;
    logic [vhtc_pkg::PLANE_W-1:0] s_eff;
    logic [vhtc_pkg::COL_W-1:0]   col_eff;
    logic [vhtc_pkg::X_W-1:0]     x_eff;
    logic [vhtc_pkg::X_W-1:0]     z_eff;
    logic                         any_eff;
    logic                         has_below;
    logic                         has_above;
    logic [vhtc_pkg::PLANE_W-1:0] total;
    logic                         live;
    logic                         below_plane;
    logic [vhtc_pkg::PLANE_W-1:0] p;
    logic [vhtc_pkg::PLANE_W-1:0] py;
    logic                         in_section;
    logic                         last_col;
    logic                         accept;
    logic                         step;
    logic [vhtc_pkg::COL_W:0]     ahead_sum;
    logic [vhtc_pkg::COL_W-1:0]   ahead_addr;
    logic [vhtc_pkg::TILE_W-1:0]  ahead_tile;

    // a section start restarts the counters with this beat
    assign start   = tiles.section_start;
    assign s_eff   = start ? '0 : plane_reg;
    assign col_eff = start ? '0 : col_reg;
    assign x_eff   = start ? '0 : x_reg;
    assign z_eff   = start ? '0 : z_reg;
    assign any_eff = start ? 1'b0 : any_reg;

    // planes below and above the section present in the stream
    assign has_below = cfg.section_base_height != '0;
    assign has_above = (vhtc_pkg::HGT_W'(cfg.section_base_height) +
                        vhtc_pkg::HGT_W'(vhtc_pkg::SECTION_HEIGHT)) <
                       vhtc_pkg::HGT_W'(vhtc_pkg::WORLD_HEIGHT);
    assign total = vhtc_pkg::PLANE_W'(vhtc_pkg::SECTION_HEIGHT) +
                   vhtc_pkg::PLANE_W'(has_below) + vhtc_pkg::PLANE_W'(has_above);
    assign live  = s_eff < total;

    // classify the beat
    assign below_plane = has_below && (s_eff == '0);
    assign p           = s_eff - vhtc_pkg::PLANE_W'(has_below);
    assign py          = p - vhtc_pkg::PLANE_W'(1);
    assign in_section  = !below_plane && (p < vhtc_pkg::PLANE_W'(vhtc_pkg::SECTION_HEIGHT));
    assign last_col    = col_eff == vhtc_pkg::COL_W'(vhtc_pkg::PLANE_TILES - 1);

    assign accept = tiles.valid && tiles.ready;
    assign step   = accept && live;
    assign tiles.ready = !f1_v_reg || ent_ready;

    // read the tile store one row of the plane ahead of the write
    assign ahead_sum  = {1'b0, col_eff} + (vhtc_pkg::COL_W + 1)'(vhtc_pkg::SECTION_WIDTH);
    assign ahead_addr = (ahead_sum >= (vhtc_pkg::COL_W + 1)'(vhtc_pkg::PLANE_TILES)) ?
        vhtc_pkg::COL_W'(ahead_sum - (vhtc_pkg::COL_W + 1)'(vhtc_pkg::PLANE_TILES)) :
        vhtc_pkg::COL_W'(ahead_sum);

    vhtc_ram #(
        .WIDTH (vhtc_pkg::TILE_W),
        .DEPTH (vhtc_pkg::PLANE_TILES)
    ) u_tile_store (
        .clk     (clk),
        .wr_en   (step),
        .wr_addr (col_eff),
        .wr_data (tiles.tile_in),
        .rd_en   (step),
        .rd_addr (ahead_addr),
        .rd_data (ahead_tile)
    );

    // counters and solid flag
    always_comb
    begin
        plane_next = plane_reg;
        col_next   = col_reg;
        x_next     = x_reg;
        z_next     = z_reg;
        any_next   = any_reg;
        if (accept)
        begin
            plane_next = s_eff;
            col_next   = col_eff;
            x_next     = x_eff;
            z_next     = z_eff;
            any_next   = any_eff;
            if (live)
            begin
                any_next = any_eff || (in_section && (tiles.tile_in != '0));
                if (last_col)
                begin
                    col_next   = '0;
                    x_next     = '0;
                    z_next     = '0;
                    plane_next = s_eff + vhtc_pkg::PLANE_W'(1);
                end
                else
                begin
                    col_next = col_eff + vhtc_pkg::COL_W'(1);
                    if (x_eff == vhtc_pkg::X_W'(vhtc_pkg::SECTION_WIDTH - 1))
                    begin
                        x_next = '0;
                        z_next = z_eff + vhtc_pkg::X_W'(1);
                    end
                    else
                    begin
                        x_next = x_eff + vhtc_pkg::X_W'(1);
                    end
                end
            end
        end
    end

    // stage record, aligned with the registered read of the tile store
    always_comb
    begin
        f1_next             = f1_reg;
        f1_next.tile        = tiles.tile_in;
        f1_next.ahead_tile  = '0;
        f1_next.x           = x_eff;
        f1_next.z           = z_eff;
        f1_next.y_lo        = vhtc_pkg::POS_W'(py);
        f1_next.y_hi        = vhtc_pkg::POS_W'(p);
        f1_next.start       = start;
        f1_next.below_plane = below_plane;
        f1_next.emit0       = !below_plane && (p != '0);
        f1_next.emit1       = !below_plane && !has_above &&
                              (p == vhtc_pkg::PLANE_W'(vhtc_pkg::SECTION_HEIGHT - 1));
        f1_next.top_height  = (vhtc_pkg::HGT_W'(cfg.section_base_height) +
                               vhtc_pkg::HGT_W'(py)) ==
                              vhtc_pkg::HGT_W'(vhtc_pkg::WORLD_HEIGHT - 1);
        f1_next.last0       = last_col && (p == vhtc_pkg::PLANE_W'(vhtc_pkg::SECTION_HEIGHT));
        f1_next.last1       = last_col;
        f1_next.empty       = !(any_eff || (in_section && (tiles.tile_in != '0)));
        f1_v_next           = f1_v_reg;
        if (tiles.ready)
        begin
            f1_v_next = step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
            col_reg   <= '0;
            x_reg     <= '0;
            z_reg     <= '0;
            any_reg   <= 1'b0;
            f1_v_reg  <= 1'b0;
        end
        else
        begin
            plane_reg <= plane_next;
            col_reg   <= col_next;
            x_reg     <= x_next;
            z_reg     <= z_next;
            any_reg   <= any_next;
            f1_v_reg  <= f1_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            f1_reg <= f1_next;
        end
    end

    // hand the record and the read-ahead tile to the queue
    always_comb
    begin
        ent            = f1_reg;
        ent.ahead_tile = ahead_tile;
    end
    assign ent_valid = f1_v_reg;

endmodule

// ----- hw/rtl/vhtc_queue.sv -----
module vhtc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  vhtc_pkg::entry_t push_data,
    input  logic             push_valid,
    output logic             push_ready,
    output vhtc_pkg::entry_t pop_data,
    output logic             pop_valid,
    input  logic             pop_ready
);

    vhtc_pkg::entry_t            mem [vhtc_pkg::QUEUE_DEPTH];
    logic [vhtc_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [vhtc_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [vhtc_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                        push;
    logic                        pop;

    assign push_ready = count_reg != vhtc_pkg::QCNT_W'(vhtc_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == vhtc_pkg::QPTR_W'(vhtc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + vhtc_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == vhtc_pkg::QPTR_W'(vhtc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + vhtc_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + vhtc_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - vhtc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= vhtc_pkg::QCNT_W'(vhtc_pkg::QUEUE_DEPTH))
        else $error("queue fill count beyond depth");
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("empty queue with pointers apart");
    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == vhtc_pkg::QCNT_W'(vhtc_pkg::QUEUE_DEPTH) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("full queue with pointers apart");
`endif

endmodule

// ----- hw/rtl/vhtc_back.sv -----
module vhtc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  vhtc_pkg::entry_t ent,
    input  logic             ent_valid,
    output logic             ent_ready,
    input  vhtc_pkg::cfg_t   cfg,
    vhtc_out_if.source       results
);

    localparam int SW = vhtc_pkg::SECTION_WIDTH;

    logic [vhtc_pkg::TILE_W-1:0]      win_reg [vhtc_pkg::WIN_LEN];
    logic [vhtc_pkg::TILE_W-1:0]      win_next [vhtc_pkg::WIN_LEN];
    logic [vhtc_pkg::PLANE_TILES-1:0] below_reg, below_next;
    logic                             s0_v_reg, s0_v_next;
    logic                             s1_v_reg, s1_v_next;
    vhtc_pkg::result_t                s0_reg, s0_next;
    vhtc_pkg::result_t                s1_reg, s1_next;

    logic                             pop;
    logic                             out_fire;
    logic                             below_old;
    logic [vhtc_pkg::TILE_W-1:0]      center;
    logic                             interior;
    logic                             hidden;
    logic                             below_bit;
    vhtc_pkg::result_t                r0;
    vhtc_pkg::result_t                r1;

    // take an entry once both result slots are free after this cycle
    assign out_fire  = results.valid && results.ready;
    assign ent_ready = !s1_v_reg && (!s0_v_reg || results.ready);
    assign pop       = ent_valid && ent_ready;

    // window over the previous plane, newest tile one row ahead of the center
    always_comb
    begin
        win_next[0] = ent.ahead_tile;
        for (int i = 1; i < vhtc_pkg::WIN_LEN; i++)
        begin
            win_next[i] = win_reg[i-1];
        end
    end

    assign center    = win_next[SW];
    assign below_old = ent.start ? 1'b1 : below_reg[vhtc_pkg::PLANE_TILES-1];
    assign interior  = (ent.x != '0) && (ent.x != vhtc_pkg::X_W'(SW - 1)) &&
                       (ent.z != '0) && (ent.z != vhtc_pkg::X_W'(SW - 1));

    // six-neighbor enclosure test
    assign hidden = ent.emit0 && interior && !ent.top_height && below_old &&
                    vhtc_pkg::cullable(center, cfg) &&
                    vhtc_pkg::cullable(win_next[SW-1], cfg) &&
                    vhtc_pkg::cullable(win_next[SW+1], cfg) &&
                    vhtc_pkg::cullable(win_next[0], cfg) &&
                    vhtc_pkg::cullable(win_next[2*SW], cfg) &&
                    vhtc_pkg::cullable(ent.tile, cfg);

    // cullable mask of the plane below, one bit per column
    always_comb
    begin
        if (ent.below_plane)
        begin
            below_bit = vhtc_pkg::cullable(ent.tile, cfg);
        end
        else if (ent.emit0)
        begin
            below_bit = vhtc_pkg::cullable(center, cfg);
        end
        else
        begin
            below_bit = below_old;
        end
        if (ent.start)
        begin
            below_next = {{(vhtc_pkg::PLANE_TILES-1){1'b1}}, below_bit};
        end
        else
        begin
            below_next = {below_reg[vhtc_pkg::PLANE_TILES-2:0], below_bit};
        end
    end

    // result of the plane below this beat and of the top plane itself
    always_comb
    begin
        r0.tile_out      = hidden ? vhtc_pkg::TILE_HIDDEN : center;
        r0.pos_x         = vhtc_pkg::POS_W'(ent.x);
        r0.pos_z         = vhtc_pkg::POS_W'(ent.z);
        r0.pos_y         = ent.y_lo;
        r0.section_empty = ent.last0 && ent.empty;
        r0.last          = ent.last0;
        r1.tile_out      = ent.tile;
        r1.pos_x         = vhtc_pkg::POS_W'(ent.x);
        r1.pos_z         = vhtc_pkg::POS_W'(ent.z);
        r1.pos_y         = ent.y_hi;
        r1.section_empty = ent.last1 && ent.empty;
        r1.last          = ent.last1;
    end

    // two-slot output register
    always_comb
    begin
        s0_v_next = s0_v_reg;
        s1_v_next = s1_v_reg;
        s0_next   = s0_reg;
        s1_next   = s1_reg;
        if (out_fire)
        begin
            s0_v_next = s1_v_reg;
            s0_next   = s1_reg;
            s1_v_next = 1'b0;
        end
        if (pop)
        begin
            if (ent.emit0)
            begin
                s0_next   = r0;
                s0_v_next = 1'b1;
                s1_next   = r1;
                s1_v_next = ent.emit1;
            end
            else
            begin
                s0_next   = r1;
                s0_v_next = ent.emit1;
                s1_v_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg  <= 1'b0;
            s1_v_reg  <= 1'b0;
            below_reg <= '1;
        end
        else
        begin
            s0_v_reg <= s0_v_next;
            s1_v_reg <= s1_v_next;
            if (pop)
            begin
                below_reg <= below_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= s0_next;
        s1_reg <= s1_next;
        if (pop)
        begin
            for (int i = 0; i < vhtc_pkg::WIN_LEN; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    assign results.valid         = s0_v_reg;
    assign results.tile_out      = s0_reg.tile_out;
    assign results.pos_x         = s0_reg.pos_x;
    assign results.pos_z         = s0_reg.pos_z;
    assign results.pos_y         = s0_reg.pos_y;
    assign results.section_empty = s0_reg.section_empty;
    assign results.last          = s0_reg.last;

`ifndef SYNTHESIS
    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg |-> s0_v_reg)
        else $error("second result slot filled ahead of the first");
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.last |->
        results.pos_x == vhtc_pkg::POS_W'(SW - 1) && results.pos_z == vhtc_pkg::POS_W'(SW - 1))
        else $error("last result away from the far corner");
    a_empty_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.section_empty |-> results.last)
        else $error("empty flag on a result that is not last");
    a_border_kept: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (ent.x == '0 || ent.z == '0) |-> !hidden)
        else $error("border tile hidden");
`endif

endmodule

// ----- hw/rtl/voxel_hidden_tile_cull.sv -----
// Hidden tile cull for one 16x16x16 voxel section. Tile ids arrive on tiles one
// beat per cycle while ready is high, x fastest then z then plane, starting with
// the plane below the section when the section base is above the floor and ending
// with the plane above when one exists; section_start on a beat restarts the
// stream. Each section tile comes out on results one plane late (the top plane
// at once if none is above), as 255 when it and its six neighbors are all cullable,
// else unchanged, with its position; section_empty and last ride on the final
// beat. The block takes one tile and gives one result per cycle while results
// is ready, so it runs at one tile per cycle except on the top plane of a section
// with no plane above, where each tile yields two results and the single result
// port holds the stream back. Tiles pass through the front stage, the queue and
// the output register. The previous plane lives in a 256x8 RAM read one row ahead
// of the write into a 33-tile window; cullability of the plane below is a 256-bit
// mask set to all ones on reset and on section start, so no clearing pass is
// needed. Configuration is written through cfg_wr_en, cfg_index and cfg_data
// and must only change while no results are pending.
module voxel_hidden_tile_cull (
    input  logic                           clk,
    input  logic                           rst_n,
    vhtc_in_if.sink                        tiles,
    vhtc_out_if.source                     results,
    input  logic                           cfg_wr_en,
    input  logic [vhtc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vhtc_pkg::REG_W-1:0]     cfg_data
);

    vhtc_pkg::cfg_t   cfg_reg, cfg_next;
    vhtc_pkg::entry_t front_ent;
    logic             front_valid;
    logic             front_ready;
    vhtc_pkg::entry_t back_ent;
    logic             back_valid;
    logic             back_ready;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (vhtc_pkg::cfg_reg_t'(cfg_index))
                vhtc_pkg::REG_SECTION_BASE: cfg_next.section_base_height = cfg_data;
                vhtc_pkg::REG_CULL_KIND_A:  cfg_next.cull_kind_a = cfg_data;
                vhtc_pkg::REG_CULL_KIND_B:  cfg_next.cull_kind_b = cfg_data;
                vhtc_pkg::REG_CULL_KIND_C:  cfg_next.cull_kind_c = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.section_base_height <= vhtc_pkg::REG_W'(0);
            cfg_reg.cull_kind_a         <= vhtc_pkg::REG_W'(1);
            cfg_reg.cull_kind_b         <= vhtc_pkg::REG_W'(3);
            cfg_reg.cull_kind_c         <= vhtc_pkg::REG_W'(7);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // classify and buffer the incoming tiles
    vhtc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .tiles     (tiles),
        .cfg       (cfg_reg),
        .ent       (front_ent),
        .ent_valid (front_valid),
        .ent_ready (front_ready)
    );

    vhtc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_ent),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (back_ent),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    // stencil test and result delivery
    vhtc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ent       (back_ent),
        .ent_valid (back_valid),
        .ent_ready (back_ready),
        .cfg       (cfg_reg),
        .results   (results)
    );

endmodule

// ----- tb/sv/vhtc_cull_checker.sv -----
`timescale 1ns / 1ps

module vhtc_cull_checker
    import vhtc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    vhtc_in_if                   tiles,
    vhtc_out_if                  results,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    output int                   error_count,
    output int                   pending
);

    // shadow of the configuration registers
    cfg_t cfg_copy;

    // two planes of tile ids, cullability of the plane under each column
    logic [TILE_W-1:0] plane_bank [2][PLANE_TILES];
    bit                under_ok [PLANE_TILES];
    int                col_pos;
    int                plane_pos;
    bit                saw_solid;

    // section tiles still owed by the block, oldest first
    result_t culled_q [$];
    int      mismatches = 0;

    assign error_count = mismatches;

    function automatic bit hideable(input logic [TILE_W-1:0] id);
        return id == cfg_copy.cull_kind_a || id == cfg_copy.cull_kind_b ||
               id == cfg_copy.cull_kind_c || id == TILE_HIDDEN;
    endfunction

    task automatic push_result(input logic [TILE_W-1:0] tile, input int xi, input int zi,
                               input int yi, input bit last);
        result_t r;
        r.tile_out      = tile;
        r.pos_x         = POS_W'(xi);
        r.pos_z         = POS_W'(zi);
        r.pos_y         = POS_W'(yi);
        r.section_empty = last && !saw_solid;
        r.last          = last;
        culled_q.insert(culled_q.size(), r);
    endtask

    // one accepted tile beat: store it and emit the section tiles it completes
    task automatic advance_stream(input logic [TILE_W-1:0] tile, input logic start);
        int                has_below;
        int                has_above;
        int                plane_total;
        int                col;
        int                xi;
        int                zi;
        int                p;
        int                py;
        int                old_bank;
        logic [TILE_W-1:0] centre;
        logic [TILE_W-1:0] shown;
        bit                enclosed;
        if (start)
        begin
            plane_pos = 0;
            col_pos   = 0;
            saw_solid = 1'b0;
            foreach (under_ok[i]) under_ok[i] = 1'b1;
        end
        has_below   = (cfg_copy.section_base_height != 0) ? 1 : 0;
        has_above   = (int'(cfg_copy.section_base_height) + SECTION_HEIGHT < WORLD_HEIGHT)
                      ? 1 : 0;
        plane_total = has_below + SECTION_HEIGHT + has_above;
        // stream already complete: tile is dropped
        if (plane_pos >= plane_total || col_pos >= PLANE_TILES)
            return;

        col      = col_pos;
        xi       = col % SECTION_WIDTH;
        zi       = col / SECTION_WIDTH;
        old_bank = (plane_pos + 1) % 2;
        plane_bank[plane_pos % 2][col] = tile;

        if (has_below == 1 && plane_pos == 0)
        begin
            under_ok[col] = hideable(tile);
        end
        else
        begin
            p = plane_pos - has_below;
            // previous plane tile is now fully surrounded
            if (p >= 1)
            begin
                py       = p - 1;
                centre   = plane_bank[old_bank][col];
                enclosed = 1'b0;
                if (xi != 0 && xi != SECTION_WIDTH - 1 && zi != 0 && zi != SECTION_WIDTH - 1)
                begin
                    enclosed = int'(cfg_copy.section_base_height) + py != WORLD_HEIGHT - 1 &&
                               hideable(centre) &&
                               hideable(plane_bank[old_bank][col - 1]) &&
                               hideable(plane_bank[old_bank][col + 1]) &&
                               hideable(plane_bank[old_bank][col - SECTION_WIDTH]) &&
                               hideable(plane_bank[old_bank][col + SECTION_WIDTH]) &&
                               under_ok[col] && hideable(tile);
                end
                shown         = enclosed ? TILE_HIDDEN : centre;
                under_ok[col] = hideable(centre);
                push_result(shown, xi, zi, py,
                            p == SECTION_HEIGHT && col == PLANE_TILES - 1);
            end
            if (p < SECTION_HEIGHT)
            begin
                if (tile != 0)
                    saw_solid = 1'b1;
                // top plane with nothing streamed above goes out at once
                if (p == SECTION_HEIGHT - 1 && has_above == 0)
                    push_result(tile, xi, zi, p, col == PLANE_TILES - 1);
            end
        end

        col_pos = col + 1;
        if (col_pos >= PLANE_TILES)
        begin
            col_pos   = 0;
            plane_pos = plane_pos + 1;
        end
    endtask

    task automatic check_field(input string name, input logic [TILE_W-1:0] want_v,
                               input logic [TILE_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endtask

    // compare result beats, track config writes, predict on tile beats
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            cfg_copy.section_base_height = 8'd0;
            cfg_copy.cull_kind_a         = 8'd1;
            cfg_copy.cull_kind_b         = 8'd3;
            cfg_copy.cull_kind_c         = 8'd7;
            col_pos   = 0;
            plane_pos = 0;
            saw_solid = 1'b0;
            foreach (under_ok[i]) under_ok[i] = 1'b1;
            culled_q.delete();
            pending <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (culled_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got %0d at %0d %0d %0d",
                             $time, results.tile_out, results.pos_x, results.pos_z,
                             results.pos_y);
                end
                else
                begin
                    want = culled_q.pop_front();
                    check_field("tile_out", want.tile_out, results.tile_out);
                    check_field("pos_x", want.pos_x, results.pos_x);
                    check_field("pos_z", want.pos_z, results.pos_z);
                    check_field("pos_y", want.pos_y, results.pos_y);
                    check_field("section_empty", want.section_empty, results.section_empty);
                    check_field("last", want.last, results.last);
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_SECTION_BASE: cfg_copy.section_base_height = cfg_data;
                    REG_CULL_KIND_A:  cfg_copy.cull_kind_a         = cfg_data;
                    REG_CULL_KIND_B:  cfg_copy.cull_kind_b         = cfg_data;
                    REG_CULL_KIND_C:  cfg_copy.cull_kind_c         = cfg_data;
                    default: ;
                endcase
            end
            if (tiles.valid && tiles.ready)
                advance_stream(tiles.tile_in, tiles.section_start);
            pending <= culled_q.size();
        end
    end

endmodule

// ----- tb/sv/voxel_hidden_tile_cull_tb.sv -----
`timescale 1ns / 1ps

module voxel_hidden_tile_cull_tb;
    import vhtc_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_data;
    int                   error_count;
    int                   pending;

    // no idling on either side while set
    bit calm;

    // configuration as last written, used to shape tile content
    logic [REG_W-1:0] cur_base;
    logic [REG_W-1:0] kind_a;
    logic [REG_W-1:0] kind_b;
    logic [REG_W-1:0] kind_c;

    vhtc_in_if  tiles ();
    vhtc_out_if results ();

    voxel_hidden_tile_cull i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tiles     (tiles),
        .results   (results),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    vhtc_cull_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .tiles       (tiles),
        .results     (results),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .pending     (pending)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side back-pressure
    initial results.ready = 1'b0;
    always @(posedge clk)
        results.ready <= calm || ($urandom_range(99) >= 13);

    // run limit
    initial
    begin
        #2_000_000;
        $display("voxel_hidden_tile_cull_tb: done, errors");
        $finish;
    end

    // mostly cullable ids so that enclosed tiles are common
    function automatic logic [TILE_W-1:0] pick_tile(input int hide_pct);
        logic [TILE_W-1:0] v;
        if ($urandom_range(99) < hide_pct)
        begin
            case ($urandom_range(3))
                0:       v = kind_a;
                1:       v = kind_b;
                2:       v = kind_c;
                default: v = TILE_HIDDEN;
            endcase
        end
        else
        begin
            v = TILE_W'($urandom_range(255));
        end
        return v;
    endfunction

    // one tile beat; valid stays high on return
    task automatic send_beat(input logic [TILE_W-1:0] t, input logic s);
        while (!calm && $urandom_range(99) < 13)
        begin
            tiles.valid <= 1'b0;
            @(posedge clk);
        end
        tiles.valid         <= 1'b1;
        tiles.tile_in       <= t;
        tiles.section_start <= s;
        @(posedge clk);
        while (!tiles.ready)
            @(posedge clk);
    endtask

    // sender holds off until all owed results are out
    task automatic drain();
        int spins;
        spins = 0;
        tiles.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && spins < 20000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(input logic [REG_W-1:0] base, input logic [REG_W-1:0] a,
                              input logic [REG_W-1:0] b, input logic [REG_W-1:0] c);
        cur_base  = base;
        kind_a    = a;
        kind_b    = b;
        kind_c    = c;
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SECTION_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_index <= REG_CULL_KIND_A;
        cfg_data  <= a;
        @(posedge clk);
        cfg_index <= REG_CULL_KIND_B;
        cfg_data  <= b;
        @(posedge clk);
        cfg_index <= REG_CULL_KIND_C;
        cfg_data  <= c;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // section stream of the given length, first beat marked as start
    task automatic stream_section(input int beats, input int hide_pct, input bit zero_body);
        int below;
        int plane;
        logic [TILE_W-1:0] t;
        below = (cur_base != 0) ? 1 : 0;
        for (int i = 0; i < beats; i++)
        begin
            plane = i / PLANE_TILES;
            t     = pick_tile(hide_pct);
            if (zero_body && plane >= below && plane < below + SECTION_HEIGHT)
                t = '0;
            send_beat(t, i == 0);
        end
    endtask

    // stimulus
    initial
    begin
        logic [TILE_W-1:0] seed_tiles [12];
        rst_n               = 1'b0;
        calm                = 1'b0;
        tiles.valid         = 1'b0;
        tiles.tile_in       = '0;
        tiles.section_start = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_index           = REG_SECTION_BASE;
        cfg_data            = '0;
        cur_base            = 8'd0;
        kind_a              = 8'd1;
        kind_b              = 8'd3;
        kind_c              = 8'd7;
        seed_tiles = '{8'h00, 8'hff, 8'h01, 8'h03, 8'h07, 8'h80,
                       8'h55, 8'haa, 8'h0f, 8'hf0, 8'h7f, 8'hfe};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stream straight out of reset with no start, then a restart
        foreach (seed_tiles[i]) send_beat(seed_tiles[i], 1'b0);
        send_beat(8'hff, 1'b1);
        foreach (seed_tiles[i])
            if (i < 11)
                send_beat(~seed_tiles[i], 1'b0);
        drain();

        // world floor section at full rate into the second plane
        set_config(8'd0, 8'd1, 8'd3, 8'd7);
        calm = 1'b1;
        stream_section(330, 90, 1'b0);
        calm = 1'b0;
        drain();

        // top of the world: dropped part way, then restarted past the plane below
        set_config(8'd240, 8'd0, 8'd255, 8'd128);
        stream_section(100 + $urandom_range(50), 90, 1'b0);
        stream_section(580, 92, 1'b0);
        drain();

        // random settings
        set_config(REG_W'(16 * $urandom_range(15)), REG_W'($urandom_range(255)),
                   REG_W'($urandom_range(255)), REG_W'($urandom_range(255)));
        stream_section(200, 85, $urandom_range(3) == 0);
        drain();

        if (error_count == 0 && pending == 0)
            $display("voxel_hidden_tile_cull_tb: done, clean");
        else
            $display("voxel_hidden_tile_cull_tb: done, errors");
        $finish;
    end

endmodule
